// File: rtl/core/gib_pkg.sv
// ----------------------------------------------------------------------------
// gib_pkg
// Shared types, constants and helpers for the grid index boundary flag block.
// ----------------------------------------------------------------------------
package gib_pkg;

  localparam int IDX_W      = 30;  // width of a linear grid index
  localparam int CFG_W      = 11;  // width of an axis size register
  localparam int CFG_IDX_W  = 2;   // width of the register index
  localparam int NUM_AXES   = 3;
  localparam int DIV_STEP   = 4;   // quotient bits resolved per pipeline stage, at most (an axis' last does 2)
  localparam int SZ_MAX_W   = 17;  // widest effective size (MAX_AXIS up to 65536)
  localparam int MAX_AXIS_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] grid_index;
  } in_t;

  typedef struct packed {
    logic [NUM_AXES-1:0] lower_flags;
    logic [NUM_AXES-1:0] upper_flags;
  } out_t;

  // Lower and upper boundary test for one axis; coord < size always holds.
  function automatic logic [1:0] axis_flags(input logic [SZ_MAX_W-1:0] coord,
                                            input logic [SZ_MAX_W-1:0] size,
                                            input logic                cube);
    logic [SZ_MAX_W:0] reach;
    logic              lo;
    logic              up;
    reach = {1'b0, coord} + (cube ? (SZ_MAX_W+1)'(2) : (SZ_MAX_W+1)'(1));
    lo    = (coord == '0);
    up    = (reach >= {1'b0, size});
    return {up, lo};
  endfunction

endpackage

// File: rtl/core/gib_div_stage.sv
// ----------------------------------------------------------------------------
// gib_div_stage
// One pipeline stage of a restoring divider: resolves a few quotient bits of
// the running index against one axis size. The first stage of an axis starts
// a fresh remainder and folds the previous axis' remainder into the flags.
// ----------------------------------------------------------------------------
module gib_div_stage
  import gib_pkg::*;
#(
  parameter int RW    = 11,  // remainder width
  parameter int NSTEP = 4,   // quotient bits done here
  parameter bit FIRST = 1'b0,
  parameter int AXIS  = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic                up_mode,
  input  logic [RW-1:0]       up_rem,
  input  logic [IDX_W-1:0]    up_quot,
  input  logic [NUM_AXES-1:0] up_lower,
  input  logic [NUM_AXES-1:0] up_upper,
  input  logic [RW-1:0]       size,
  input  logic [RW-1:0]       prev_size,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic                dn_mode,
  output logic [RW-1:0]       dn_rem,
  output logic [IDX_W-1:0]    dn_quot,
  output logic [NUM_AXES-1:0] dn_lower,
  output logic [NUM_AXES-1:0] dn_upper
);

  logic                valid_r;
  logic                mode_r;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [IDX_W-1:0]    quot_r, quot_nxt;
  logic [NUM_AXES-1:0] lower_r, lower_nxt;
  logic [NUM_AXES-1:0] upper_r, upper_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    logic [RW:0]   trial;
    logic [RW-1:0] r;
    logic [IDX_W-1:0] q;
    logic [1:0]    fl;
    lower_nxt = up_lower;
    upper_nxt = up_upper;
    fl        = '0;
    if (FIRST) begin
      r = '0;
      if (AXIS > 0) begin
        fl = axis_flags(SZ_MAX_W'(up_rem), SZ_MAX_W'(prev_size), up_mode);
        lower_nxt[(AXIS > 0) ? AXIS-1 : 0] = fl[0];
        upper_nxt[(AXIS > 0) ? AXIS-1 : 0] = fl[1];
      end
    end else begin
      r = up_rem;
    end
    q = up_quot;
    for (int i = 0; i < NSTEP; i++) begin
      trial = {r, q[IDX_W-1]};
      if (trial >= {1'b0, size}) begin
        trial = trial - {1'b0, size};
        q     = {q[IDX_W-2:0], 1'b1};
      end else begin
        q     = {q[IDX_W-2:0], 1'b0};
      end
      r = trial[RW-1:0];
    end
    rem_nxt  = r;
    quot_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      mode_r  <= up_mode;
      rem_r   <= rem_nxt;
      quot_r  <= quot_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_mode  = mode_r;
  assign dn_rem   = rem_r;
  assign dn_quot  = quot_r;
  assign dn_lower = lower_r;
  assign dn_upper = upper_r;

endmodule

// File: rtl/core/grid_index_boundary_bits.sv
// ----------------------------------------------------------------------------
// grid_index_boundary_bits
// Boundary flags of a grid vertex or cube from its linear index.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry a request {mode, grid_index}; mode 0 names a
//   vertex, mode 1 a cube by its lowest corner. out_valid/out_ready return
//   {lower_flags, upper_flags}, one result per request, in order.
//   cfg_we writes cfg_wdata into the axis size selected by cfg_index
//   (0 = x, 1 = y, 2 = z, others ignored); write only while the block is idle.
//   The index is split into coordinates by three restoring dividers, each
//   cut into ceil(30/4) = 8 stages of up to four quotient bits, plus one
//   output stage; throughput is one request per cycle while out_ready is high.
//   Every stage holds its own valid bit and takes a new request whenever it
//   is empty or its successor moves, so bubbles collapse; when out_ready is
//   low the pipe fills up and in_ready drops only once every stage is full.
//   Synchronous reset empties the pipe and sets all axis sizes to 1.
// ----------------------------------------------------------------------------
module grid_index_boundary_bits
  import gib_pkg::*;
#(
  parameter int MAX_AXIS = MAX_AXIS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int RW   = $clog2(MAX_AXIS + 1);
  localparam int NS   = (IDX_W + DIV_STEP - 1) / DIV_STEP;
  localparam int NSTG = NUM_AXES * NS;
  localparam int CW   = (RW > CFG_W) ? RW : CFG_W;

  logic [CFG_W-1:0] size_r [NUM_AXES];
  logic [RW-1:0]    eff    [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_AXES; d++) size_r[d] <= CFG_W'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SIZE_X: size_r[0] <= cfg_wdata;
        REG_SIZE_Y: size_r[1] <= cfg_wdata;
        REG_SIZE_Z: size_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero reads as one, oversize clamps to MAX_AXIS.
  always_comb begin
    logic [CW-1:0] raw;
    for (int d = 0; d < NUM_AXES; d++) begin
      raw = CW'(size_r[d]);
      if (raw == '0) begin
        eff[d] = RW'(1);
      end else if (raw > CW'(MAX_AXIS)) begin
        eff[d] = RW'(MAX_AXIS);
      end else begin
        eff[d] = raw[RW-1:0];
      end
    end
  end

  logic                v_c    [NSTG+1];
  logic                rdy_c  [NSTG+1];
  logic                mode_c [NSTG+1];
  logic [RW-1:0]       rem_c  [NSTG+1];
  logic [IDX_W-1:0]    quot_c [NSTG+1];
  logic [NUM_AXES-1:0] lo_c   [NSTG+1];
  logic [NUM_AXES-1:0] up_c   [NSTG+1];

  assign v_c[0]    = in_valid;
  assign in_ready  = rdy_c[0];
  assign mode_c[0] = in_data.mode;
  assign rem_c[0]  = '0;
  assign quot_c[0] = in_data.grid_index;
  assign lo_c[0]   = '0;
  assign up_c[0]   = '0;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int AX  = s / NS;
    localparam int LOC = s % NS;
    localparam int LEFT = IDX_W - LOC * DIV_STEP;
    gib_div_stage #(
      .RW    (RW),
      .NSTEP ((LEFT < DIV_STEP) ? LEFT : DIV_STEP),
      .FIRST (LOC == 0),
      .AXIS  (AX)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (v_c[s]),
      .up_ready  (rdy_c[s]),
      .up_mode   (mode_c[s]),
      .up_rem    (rem_c[s]),
      .up_quot   (quot_c[s]),
      .up_lower  (lo_c[s]),
      .up_upper  (up_c[s]),
      .size      (eff[AX]),
      .prev_size (eff[(AX > 0) ? AX-1 : 0]),
      .dn_valid  (v_c[s+1]),
      .dn_ready  (rdy_c[s+1]),
      .dn_mode   (mode_c[s+1]),
      .dn_rem    (rem_c[s+1]),
      .dn_quot   (quot_c[s+1]),
      .dn_lower  (lo_c[s+1]),
      .dn_upper  (up_c[s+1])
    );
  end

  // Output stage: fold in the last axis and hold the result for the receiver.
  logic       out_valid_r;
  out_t       out_data_r, out_data_nxt;
  logic [1:0] last_fl;

  assign rdy_c[NSTG] = !out_valid_r || out_ready;

  always_comb begin
    last_fl = axis_flags(SZ_MAX_W'(rem_c[NSTG]), SZ_MAX_W'(eff[NUM_AXES-1]),
                         mode_c[NSTG]);
    out_data_nxt.lower_flags = lo_c[NSTG];
    out_data_nxt.upper_flags = up_c[NSTG];
    out_data_nxt.lower_flags[NUM_AXES-1] = last_fl[0];
    out_data_nxt.upper_flags[NUM_AXES-1] = last_fl[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_c[NSTG]) begin
      out_valid_r <= v_c[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c[NSTG]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low with room in the pipe");

  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid right after reset");

  a_sizes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (eff[0] != '0) && (eff[1] != '0) && (eff[2] != '0))
    else $error("effective axis size is zero");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams vertex and cube indices through the boundary flag block under
// several axis-size settings and idle patterns, predicting each flag pair
// and comparing it with the result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import gib_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 25;
  localparam int AXIS_CAP = 1024;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_taken = 1'b0;

  grid_index_boundary_bits uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_t pending_reqs[$];
  out_t expected_flags[$];
  logic [CFG_W-1:0] size_model [NUM_AXES];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  function automatic out_t boundary_flags(in_t req);
    out_t r;
    logic [IDX_W-1:0] k;
    int unsigned sz, c, reach;
    r = '0;
    k = req.grid_index;
    reach = req.mode ? 2 : 1;
    for (int d = 0; d < NUM_AXES; d++) begin
      sz = 32'(size_model[d]);
      if (sz == 0) sz = 1;
      if (sz > AXIS_CAP) sz = AXIS_CAP;
      c = 32'(k) % sz;
      k = IDX_W'(32'(k) / sz);
      r.lower_flags[d] = (c == 0);
      r.upper_flags[d] = (c + reach >= sz);
    end
    return r;
  endfunction

  // driver: hold a request until accepted, then advance
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs[0];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_flags.push_back(boundary_flags(in_data));
        void'(pending_reqs.pop_front());
      end
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.lower_flags !== expected_flags[0].lower_flags)
            begin
            $display("%0t: lower_flags expected %b actual %b", $time,
                     expected_flags[0].lower_flags, out_data.lower_flags);
            errors++;
          end
          if (out_data.upper_flags !== expected_flags[0].upper_flags) begin
            $display("%0t: upper_flags expected %b actual %b", $time,
                     expected_flags[0].upper_flags, out_data.upper_flags);
            errors++;
          end
          void'(expected_flags.pop_front());
        end
      end
    end
  end

  task automatic write_size(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z)
      size_model[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_flags.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(5))
      0: return CFG_W'($urandom_range(1, 4));
      1: return CFG_W'($urandom_range(1, 40));
      2: return CFG_W'(AXIS_CAP);
      3: return CFG_W'($urandom_range(0, 2047));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic random_reqs(int n);
    in_t r;
    int unsigned span;
    span = 1;
    for (int d = 0; d < NUM_AXES; d++)
      span *= (size_model[d] == 0) ? 1 :
              (size_model[d] > AXIS_CAP ? AXIS_CAP : 32'(size_model[d]));
    for (int i = 0; i < n; i++) begin
      r.mode = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) r.grid_index = IDX_W'($urandom());
      else r.grid_index = IDX_W'($urandom_range(span + span / 8));
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    in_t r;
    for (int d = 0; d < NUM_AXES; d++) size_model[d] = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    out_ready <= 1'b1;

    // directed: reset sizes, then extremes and special cases
    pending_reqs.push_back('{mode: 1'b0, grid_index: '0});
    pending_reqs.push_back('{mode: 1'b1, grid_index: '1});
    drain();
    write_size(REG_SIZE_X, 3);
    write_size(REG_SIZE_Y, 0);
    write_size(REG_SIZE_Z, 2047);
    for (int i = 0; i < 8; i++) begin
      r.mode = i[0];
      r.grid_index = (i < 6) ? IDX_W'(i) : (i == 6 ? {IDX_W{1'b1}} : IDX_W'(3 * 1024 + 2));
      pending_reqs.push_back(r);
    end
    drain();
    write_size(REG_SIZE_X, 2);
    write_size(REG_SIZE_Y, 1024);
    write_size(REG_SIZE_Z, 5);
    for (int i = 0; i < 12; i++) begin
      r.mode = i[0];
      r.grid_index = (i < 4) ? IDX_W'(i * 2047) : IDX_W'($urandom_range(20480 + 30));
      pending_reqs.push_back(r);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      write_size(REG_SIZE_X, pick_size());
      write_size(REG_SIZE_Y, pick_size());
      write_size(REG_SIZE_Z, pick_size());
      random_reqs(60);
      // pause the sender until every result is back, then resume
      while (pending_reqs.size() > 0 || in_valid || expected_flags.size() > 0)
        @(posedge clk);
      random_reqs(55);
      drain();
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// File: sim.f
rtl/core/gib_pkg.sv
rtl/core/gib_div_stage.sv
rtl/core/grid_index_boundary_bits.sv
tb/tb_top.sv
